>>> rtl/mahd_pkg.sv
// Package for the MPEG audio frame header decoder.
// Holds the transaction types, status codes and lookup tables.
// No dependencies.
package mahd_pkg;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NO_SYNC  = 3'd1;
  localparam logic [2:0] STAT_CORRUPT  = 3'd2;
  localparam logic [2:0] STAT_FREE     = 3'd3;
  localparam logic [2:0] STAT_INCOMPAT = 3'd4;

  localparam logic [1:0] VER_MPEG1     = 2'd3;
  localparam logic [1:0] VER_RESERVED  = 2'd1;
  localparam logic [1:0] LAYER_BITS_RSV = 2'd0;
  localparam logic [1:0] LAYER_II      = 2'd1;
  localparam logic [1:0] MODE_JOINT    = 2'd1;
  localparam logic [1:0] MODE_MONO     = 2'd3;
  localparam logic [1:0] RATE_IDX_RSV  = 2'd3;
  localparam logic [1:0] EMPH_RSV      = 2'd2;
  localparam logic [3:0] BR_IDX_FREE   = 4'd0;
  localparam logic [2:0] ALLOC_LSF     = 3'd4;
  localparam logic [5:0] BOUND_FULL    = 6'd32;

  localparam logic [15:0] MODE_OK_STEREO = 16'h7FD1;
  localparam logic [15:0] MODE_OK_MONO   = 16'h07FF;

  typedef struct packed {
    logic [31:0] header_word;
    logic [31:0] reference_header;
    logic        compare_enable;
  } hdr_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  version_id;
    logic [1:0]  layer_number;
    logic        crc_present;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [10:0] samples_per_frame;
    logic        padding_slot;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [5:0]  intensity_bound;
    logic [2:0]  alloc_table_index;
  } hdr_out_t;

  localparam logic [8:0] KBPS_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KBPS_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] layer,
                                             input logic [3:0] idx);
    logic [8:0] k;
    k = '0;
    case (layer)
      2'd0:    k = lsf ? KBPS_V2_L1[idx] : KBPS_V1_L1[idx];
      2'd1:    k = lsf ? KBPS_V2_L23[idx] : KBPS_V1_L2[idx];
      2'd2:    k = lsf ? KBPS_V2_L23[idx] : KBPS_V1_L3[idx];
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] idx);
    logic [15:0] r;
    r = '0;
    case ({ver, idx})
      4'b00_00: r = 16'd11025;
      4'b00_01: r = 16'd12000;
      4'b00_10: r = 16'd8000;
      4'b10_00: r = 16'd22050;
      4'b10_01: r = 16'd24000;
      4'b10_10: r = 16'd16000;
      4'b11_00: r = 16'd44100;
      4'b11_01: r = 16'd48000;
      4'b11_10: r = 16'd32000;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] spf_lookup(input logic lsf, input logic [1:0] layer);
    logic [10:0] s;
    s = '0;
    case (layer)
      2'd0:    s = 11'd384;
      2'd1:    s = 11'd1152;
      2'd2:    s = lsf ? 11'd576 : 11'd1152;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] alloc_lookup(input logic [8:0] per_chan,
                                              input logic [15:0] rate);
    logic [2:0] a;
    a = '0;
    case (per_chan) inside
      9'd32, 9'd48:                       a = (rate == 16'd32000) ? 3'd3 : 3'd2;
      9'd96, 9'd112, 9'd128, 9'd160, 9'd192: a = (rate == 16'd48000) ? 3'd0 : 3'd1;
      default:                            a = 3'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/mahd_decode.sv
// Header field decode, validity checks and reference compare.
// Combinational; uses mahd_pkg types, codes and tables.
module mahd_decode (
  input  mahd_pkg::hdr_in_t  item,
  output mahd_pkg::hdr_out_t result
);

  logic [31:0] h;
  logic [31:0] r;
  logic        no_sync;
  logic [1:0]  ver;
  logic [1:0]  layer_bits;
  logic [1:0]  layer;
  logic        lsf;
  logic [3:0]  br_idx;
  logic [1:0]  sr_idx;
  logic [1:0]  chmode;
  logic [1:0]  modeext;
  logic [1:0]  emph;
  logic        mono;
  logic [8:0]  kbps;
  logic [8:0]  per_chan;
  logic [15:0] rate;
  logic [15:0] ref_rate;
  logic        mode_bad;
  logic        mismatch;
  logic [2:0]  alloc;

  assign h          = item.header_word;
  assign r          = item.reference_header;
  assign no_sync    = (h[31:24] != 8'hFF) || (h[23:21] != 3'b111) || (h[15:12] == 4'hF);
  assign ver        = h[20:19];
  assign layer_bits = h[18:17];
  assign layer      = 2'd3 - layer_bits;
  assign lsf        = (ver != mahd_pkg::VER_MPEG1);
  assign br_idx     = h[15:12];
  assign sr_idx     = h[11:10];
  assign chmode     = h[7:6];
  assign modeext    = h[5:4];
  assign emph       = h[1:0];
  assign mono       = (chmode == mahd_pkg::MODE_MONO);
  assign kbps       = mahd_pkg::kbps_lookup(lsf, layer, br_idx);
  assign per_chan   = mono ? kbps : {1'b0, kbps[8:1]};
  assign rate       = mahd_pkg::rate_lookup(ver, sr_idx);
  assign ref_rate   = mahd_pkg::rate_lookup(r[20:19], r[11:10]);
  assign mode_bad   = (layer == mahd_pkg::LAYER_II) && !lsf &&
                      !(mono ? mahd_pkg::MODE_OK_MONO[br_idx]
                             : mahd_pkg::MODE_OK_STEREO[br_idx]);
  assign mismatch   = (r[20:19] != ver) || (r[18:17] != layer_bits) || (ref_rate != rate) ||
                      ((r[7:6] == mahd_pkg::MODE_MONO) != mono) || (r[1:0] != emph);

  always_comb begin
    alloc = '0;
    if (layer == mahd_pkg::LAYER_II) begin
      alloc = lsf ? mahd_pkg::ALLOC_LSF : mahd_pkg::alloc_lookup(per_chan, rate);
    end
  end

  always_comb begin
    result = '0;
    if (no_sync) begin
      result.status = mahd_pkg::STAT_NO_SYNC;
    end else if (ver == mahd_pkg::VER_RESERVED || layer_bits == mahd_pkg::LAYER_BITS_RSV) begin
      result.status = mahd_pkg::STAT_CORRUPT;
    end else if (br_idx == mahd_pkg::BR_IDX_FREE) begin
      result.status = mahd_pkg::STAT_FREE;
    end else if (sr_idx == mahd_pkg::RATE_IDX_RSV || emph == mahd_pkg::EMPH_RSV || mode_bad) begin
      result.status = mahd_pkg::STAT_CORRUPT;
    end else begin
      result.status            = (item.compare_enable && mismatch) ? mahd_pkg::STAT_INCOMPAT
                                                                   : mahd_pkg::STAT_OK;
      result.version_id        = ver;
      result.layer_number      = layer;
      result.crc_present       = ~h[16];
      result.bitrate_kbps      = kbps;
      result.sample_rate_hz    = rate;
      result.samples_per_frame = mahd_pkg::spf_lookup(lsf, layer);
      result.padding_slot      = h[9];
      result.channel_mode      = chmode;
      result.mode_extension    = modeext;
      result.intensity_bound   = (chmode == mahd_pkg::MODE_JOINT)
                                 ? (6'd4 + {2'b00, modeext, 2'b00}) : mahd_pkg::BOUND_FULL;
      result.alloc_table_index = alloc;
    end
  end

endmodule

>>> rtl/mpeg_audio_header_decode_top.sv
// Top level of the MPEG audio frame header decoder.
// Input register, mahd_decode, result register; uses mahd_pkg.
//
// Usage: drive item (header word, reference header, compare enable) and
// raise start; the transaction is taken at the clock edge where start is
// high and busy is low. busy is high only while rst is asserted, so a new
// header can be taken on every cycle, e.g. one candidate per cycle while
// scanning a byte stream.
// The accepted item is captured in the input register, decoded
// combinationally by mahd_decode and then captured in the result
// register, where done rises with it.
// Throughput: one transaction per cycle, set by the single decode stage.
// Every accepted transaction gives exactly one result, in order.
// done is a one-cycle strobe; the receiver cannot stall and must take the
// result in that cycle.
// Reset: synchronous, active high; clears both valid flags so no result
// is produced for anything in flight.
module mpeg_audio_header_decode_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mahd_pkg::hdr_in_t  item,
  output logic               done,
  output mahd_pkg::hdr_out_t result
);

  logic               valid_s1;
  mahd_pkg::hdr_in_t  item_s1;
  mahd_pkg::hdr_out_t dec_out;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      done     <= 1'b0;
    end else begin
      valid_s1 <= start && !busy;
      done     <= valid_s1;
    end
  end

  always_ff @(posedge clk) begin
    item_s1 <= item;
    result  <= dec_out;
  end

  mahd_decode u_decode (
    .item   (item_s1),
    .result (dec_out)
  );

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction produced no result");

  a_status_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= mahd_pkg::STAT_INCOMPAT))
    else $error("status code out of range");

  a_fail_clear : assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == mahd_pkg::STAT_NO_SYNC ||
              result.status == mahd_pkg::STAT_CORRUPT ||
              result.status == mahd_pkg::STAT_FREE))
    |-> (result.sample_rate_hz == '0 && result.bitrate_kbps == '0 &&
         result.samples_per_frame == '0 && result.intensity_bound == '0))
    else $error("failed header carries decoded fields");

  a_good_full : assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == mahd_pkg::STAT_OK ||
              result.status == mahd_pkg::STAT_INCOMPAT))
    |-> (result.sample_rate_hz != '0 && result.bitrate_kbps != '0 &&
         result.samples_per_frame != '0 && result.intensity_bound >= 6'd4))
    else $error("valid header missing decoded fields");

endmodule
